>>> rtl/prq_pkg.sv
// shared types and constants for the priority ready queue insert block
// entry record, cell control group, field widths and register indexes
// no dependencies
package prq_pkg;

	localparam int QUEUE_DEPTH = 32;
	localparam int IDX_W       = $clog2(QUEUE_DEPTH);

	localparam int PRIO_W   = 11;
	localparam int TID_W    = 8;
	localparam int BASE_W   = 8;
	localparam int OFFS_W   = 10;
	localparam int POS_W    = 6;
	localparam int IDLE_W   = 8;
	localparam int ADJ_W    = 9;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_IDLE_PRIORITY = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_IDLE_ADJUST   = CFG_IDX_W'(1);

	typedef struct packed {
		logic              valid;
		logic [PRIO_W-1:0] prio;
		logic [TID_W-1:0]  tid;
		logic              atom;
	} prq_entry_t;

	// per-cell control from the top level
	typedef struct packed {
		logic upd;        // insert transaction commits this cycle
		logic le_prev;    // insert point lies at or before the left neighbor
		logic prior_stop; // some cell nearer the head stops the scan
	} prq_ctl_t;

	// per-cell status back to the top level
	typedef struct packed {
		logic stop; // scan stops at this cell
		logic le;   // insert point lies at or before this cell
		logic ins;  // new task lands in this cell
	} prq_stat_t;

endpackage

>>> rtl/priority_ready_queue_insert.sv
// sorted ready queue insertion: a row of prq_cell slots plus priority capping
// the input is registered in the s1 stage, then moves to the result register
// throughput: one insertion per cycle while the result side keeps taking results
// the insert cycle stalls only while a previous result still waits on m_axis_tready
// reset: queue empty, both ceiling registers zero, no clearing pass
// depends on prq_pkg and prq_cell
module priority_ready_queue_insert (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// task_id[7:0], base_priority[15:8], priority_offset[25:16], zero fill
	input  logic [31:0]                      s_axis_tdata,
	// atomic[0]
	input  logic [0:0]                       s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// insert_position[5:0], adjusted_offset[15:6]
	output logic [15:0]                      m_axis_tdata,
	// clamped[0], queue_full[1]
	output logic [1:0]                       m_axis_tuser,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [prq_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [prq_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import prq_pkg::*;

	logic [IDLE_W-1:0] idle_q;
	logic [ADJ_W-1:0]  adj_q;

	logic              busy_q;
	logic              advance;
	logic              accept;
	logic              full;
	logic              upd;

	logic signed [PRIO_W-1:0] base_ext;
	logic signed [PRIO_W-1:0] offs_ext;
	logic signed [PRIO_W-1:0] eff;
	logic signed [PRIO_W-1:0] ceil_v;
	logic signed [PRIO_W-1:0] offs_capped;
	logic                     clamp;

	logic [PRIO_W-1:0] eff_s1;
	logic [OFFS_W-1:0] offs_s1;
	logic              clamp_s1;
	logic [TID_W-1:0]  tid_s1;
	logic              atom_s1;

	logic              m_valid_q;
	logic [POS_W-1:0]  pos_q;
	logic [OFFS_W-1:0] offs_q;
	logic              clamp_q;
	logic              full_q;

	prq_entry_t entries [QUEUE_DEPTH];
	prq_stat_t  stats   [QUEUE_DEPTH];
	prq_ctl_t   ctls    [QUEUE_DEPTH];
	prq_entry_t new_entry;
	prq_entry_t head_entry;

	logic [QUEUE_DEPTH-1:0] stop_vec;
	logic [QUEUE_DEPTH-1:0] ins_vec;
	logic [QUEUE_DEPTH-1:0] valid_vec;
	logic [IDX_W-1:0]       pos_idx;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_q <= '0;
			adj_q  <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_IDLE_PRIORITY: idle_q <= cfg_data[IDLE_W-1:0];
				REG_IDLE_ADJUST:   adj_q  <= cfg_data[ADJ_W-1:0];
				default: ;
			endcase
		end
	end

	// handshake
	assign full          = entries[QUEUE_DEPTH-1].valid;
	assign advance       = busy_q & (~m_valid_q | m_axis_tready);
	assign upd           = advance & ~full;
	assign s_axis_tready = ~busy_q | advance;
	assign accept        = s_axis_tvalid & s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (accept) begin
			busy_q <= 1'b1;
		end else if (advance) begin
			busy_q <= 1'b0;
		end
	end

	// effective priority and capping at the ceiling
	always_comb begin
		base_ext = PRIO_W'($signed(s_axis_tdata[15:8]));
		offs_ext = PRIO_W'($signed(s_axis_tdata[25:16]));
		eff      = base_ext + offs_ext;
		ceil_v   = PRIO_W'($signed(idle_q)) + PRIO_W'($signed(adj_q));
		clamp    = eff >= ceil_v;
		offs_capped = clamp ? (ceil_v - base_ext) : offs_ext;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			eff_s1   <= clamp ? ceil_v : eff;
			offs_s1  <= offs_capped[OFFS_W-1:0];
			clamp_s1 <= clamp;
			tid_s1   <= s_axis_tdata[7:0];
			atom_s1  <= s_axis_tuser[0];
		end
	end

	// row of cells
	assign new_entry  = '{valid: 1'b1, prio: eff_s1, tid: tid_s1, atom: atom_s1};
	assign head_entry = '{valid: 1'b1, prio: '0, tid: '0, atom: 1'b0};

	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			stop_vec[i]  = stats[i].stop;
			ins_vec[i]   = stats[i].ins;
			valid_vec[i] = entries[i].valid;
		end
	end

	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			ctls[i].upd        = upd;
			ctls[i].le_prev    = (i == 0) ? 1'b0 : stats[(i == 0) ? 0 : i-1].le;
			ctls[i].prior_stop =
				|(stop_vec & ((QUEUE_DEPTH'(1) << i) - QUEUE_DEPTH'(1)));
		end
	end

	for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
		if (g == 0) begin : g_head
			prq_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctl        (ctls[g]),
				.left_entry (head_entry),
				.new_entry  (new_entry),
				.entry      (entries[g]),
				.stat       (stats[g])
			);
		end else begin : g_body
			prq_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctl        (ctls[g]),
				.left_entry (entries[g-1]),
				.new_entry  (new_entry),
				.entry      (entries[g]),
				.stat       (stats[g])
			);
		end
	end

	// one-hot landing cell to index
	always_comb begin
		pos_idx = '0;
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			pos_idx = pos_idx | (ins_vec[i] ? IDX_W'(i) : IDX_W'(0));
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pos_q   <= full ? POS_W'(0) : POS_W'(pos_idx);
			offs_q  <= offs_s1;
			clamp_q <= clamp_s1;
			full_q  <= full;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {offs_q, pos_q};
	assign m_axis_tuser  = {full_q, clamp_q};

`ifndef SYNTHESIS
	// occupied slots always form a run from the head
	a_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot({1'b0, valid_vec} + (QUEUE_DEPTH+1)'(1)))
		else $error("queue slots not contiguous from head");

	// a committed insert lands in exactly one cell
	a_one_landing: assert property (@(posedge clk) disable iff (!arst_n)
		upd |-> $onehot(ins_vec))
		else $error("insert landing cell not unique");

	// a committed insert grows the queue by one entry
	a_grow: assert property (@(posedge clk) disable iff (!arst_n)
		upd |=> $countones(valid_vec) == $past($countones(valid_vec)) + 1)
		else $error("queue occupancy did not grow by one");
`endif

endmodule

>>> rtl/prq_cell.sv
// one slot of the sorted ready queue: holds an entry, compares it with the
// incoming task and takes the new task, the left neighbor's entry or none
// depends on prq_pkg
module prq_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  prq_pkg::prq_ctl_t   ctl,
	input  prq_pkg::prq_entry_t left_entry,
	input  prq_pkg::prq_entry_t new_entry,
	output prq_pkg::prq_entry_t entry,
	output prq_pkg::prq_stat_t  stat
);
	import prq_pkg::*;

	logic              valid_q;
	logic [PRIO_W-1:0] prio_q;
	logic [TID_W-1:0]  tid_q;
	logic              atom_q;
	logic              higher;

	assign higher = $signed(new_entry.prio) > $signed(prio_q);

	always_comb begin
		stat.stop = valid_q & (atom_q | higher);
		// an atomic stop places the task after this cell, so not here
		stat.le   = ctl.prior_stop | (stat.stop & ~atom_q) | ~valid_q;
		stat.ins  = stat.le & ~ctl.le_prev;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.upd) begin
			valid_q <= valid_q | left_entry.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.upd) begin
			if (stat.ins) begin
				prio_q <= new_entry.prio;
				tid_q  <= new_entry.tid;
				atom_q <= new_entry.atom;
			end else if (ctl.le_prev) begin
				prio_q <= left_entry.prio;
				tid_q  <= left_entry.tid;
				atom_q <= left_entry.atom;
			end
		end
	end

	assign entry = '{valid: valid_q, prio: prio_q, tid: tid_q, atom: atom_q};

endmodule
